>>> hdl/xs_pkg.sv
`default_nettype none
package xs_pkg;

    localparam int WORD_W      = 64;
    localparam int HALF_W      = WORD_W / 2;
    localparam int WORD_COUNT  = 4;
    localparam int IDX_W       = $clog2(WORD_COUNT);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request opcodes
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // splitmix64 constants
    localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;

    // queued command, already decoded by the front end
    typedef struct packed {
        logic              is_draw;
        logic [WORD_W-1:0] seed;
    } cmd_t;

endpackage
`default_nettype wire

>>> hdl/xs_req_if.sv
`default_nettype none
interface xs_req_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [xs_pkg::WORD_W-1:0] seed_value;

    modport source (output valid, output op, output seed_value, input ready);
    modport sink   (input valid, input op, input seed_value, output ready);
endinterface
`default_nettype wire

>>> hdl/xs_rsp_if.sv
`default_nettype none
interface xs_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [xs_pkg::WORD_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface
`default_nettype wire

>>> hdl/xoshiro256ss_generator.sv
`default_nettype none
// xoshiro256** generator with splitmix64 seeding. A draw request (op 1)
// returns one 64-bit value and steps the 256-bit state; a seed request
// (op 0) expands seed_value into the four state words and returns nothing.
// Requests pass through a two-entry queue, so up to two requests are taken
// while a result waits on the response side. Draws execute one per cycle
// while the response side keeps up; a draw's result passes through the mid
// and out registers. A seed request holds the execution side: each of the
// four splitmix64 steps is one add, then two 64-bit multiplies of three
// 32x32 partial products each on the single shared multiplier. After reset
// the same expansion of seed zero runs first; requests are accepted
// meanwhile and execute in order once it completes.
module xoshiro256ss_generator (
    input  wire logic clk,
    input  wire logic rst_n,
    xs_req_if.sink    req,
    xs_rsp_if.source  rsp
);

    xs_pkg::cmd_t q_cmd;
    logic         q_valid;
    logic         q_pop;

    // intake and decode
    xs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // seeding sequencer, state update and output pipe
    xs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

`ifndef NO_ASSERTIONS
    // back end only pops a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // a full queue (not ready) always presents a request to the back end
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> q_valid)
        else $error("queue stalls intake but reports empty");

    // an unpopped head stays in place
    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_pop |=> q_valid && $stable(q_cmd))
        else $error("queue head changed without a pop");
`endif

endmodule
`default_nettype wire

>>> hdl/xs_front.sv
`default_nettype none
// Request intake: decodes the opcode and holds requests in a small FIFO.
module xs_front (
    input  wire logic  clk,
    input  wire logic  rst_n,
    xs_req_if.sink     req,
    output xs_pkg::cmd_t q_cmd,
    output logic       q_valid,
    input  wire logic  q_pop
);

    xs_pkg::cmd_t                  entries_reg [xs_pkg::QUEUE_DEPTH];
    logic [xs_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [xs_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [xs_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                          push;
    xs_pkg::cmd_t                  cmd_in;

    assign req.ready = (count_reg != xs_pkg::QCNT_W'(xs_pkg::QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_cmd     = entries_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.is_draw = (req.op == xs_pkg::OP_DRAW);
        cmd_in.seed    = req.seed_value;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == xs_pkg::QPTR_W'(xs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == xs_pkg::QPTR_W'(xs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

>>> hdl/xs_back.sv
`default_nettype none
// Execution: state words, splitmix64 sequencer on one shared 32x32
// multiplier, and a two-register output pipe for draws.
module xs_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire xs_pkg::cmd_t q_cmd,
    input  wire logic         q_valid,
    output logic              q_pop,
    xs_rsp_if.source          rsp
);

    localparam int W = xs_pkg::WORD_W;
    localparam int H = xs_pkg::HALF_W;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ADD  = 3'd1;
    localparam logic [2:0] PH_M0   = 3'd2;
    localparam logic [2:0] PH_M1   = 3'd3;
    localparam logic [2:0] PH_M2   = 3'd4;

    logic [2:0]                  phase_reg, phase_next;
    logic [xs_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                        sel_b_reg, sel_b_next;
    logic [W-1:0]                ctr_reg, ctr_next;
    logic [W-1:0]                mul_a_reg, mul_a_next;
    logic [W-1:0]                acc_reg, acc_next;
    logic [W-1:0]                words_reg [xs_pkg::WORD_COUNT];

    logic                        mid_valid_reg, mid_valid_next;
    logic [W-1:0]                mid_reg, mid_next;
    logic                        out_valid_reg, out_valid_next;
    logic [W-1:0]                out_reg, out_next;

    logic                        out_free, mid_advance, mid_free;
    logic                        draw_go, seed_go;
    logic [W-1:0]                mul_b, ctr_inc, fin, times5;
    logic [H-1:0]                mul_x, mul_y;
    logic [W-1:0]                mul_p;
    logic [W-1:0]                n0, n1, n2, n3;
    logic                        word_we;
    logic [W-1:0]                word_wd;

    // output pipe handshake
    assign out_free    = !out_valid_reg || rsp.ready;
    assign mid_advance = mid_valid_reg && out_free;
    assign mid_free    = !mid_valid_reg || mid_advance;

    assign draw_go = (phase_reg == PH_IDLE) && q_valid && q_cmd.is_draw && mid_free;
    assign seed_go = (phase_reg == PH_IDLE) && q_valid && !q_cmd.is_draw;
    assign q_pop   = draw_go || seed_go;

    assign rsp.valid        = out_valid_reg;
    assign rsp.random_value = out_reg;

    // shared multiplier, low 64 bits built from three partial products
    assign mul_b = sel_b_reg ? xs_pkg::MIX_MUL_B : xs_pkg::MIX_MUL_A;
    always_comb
    begin
        mul_x = mul_a_reg[H-1:0];
        mul_y = mul_b[H-1:0];
        unique case (phase_reg)
            PH_M1:
            begin
                mul_x = mul_a_reg[W-1:H];
            end
            PH_M2:
            begin
                mul_y = mul_b[W-1:H];
            end
            default:
            begin
            end
        endcase
    end
    assign mul_p   = W'(mul_x) * W'(mul_y);
    assign fin     = acc_reg + {mul_p[H-1:0], {H{1'b0}}};
    assign ctr_inc = ctr_reg + xs_pkg::GOLDEN_INC;

    // draw: state update and first half of the scrambler
    assign n2     = words_reg[2] ^ words_reg[0];
    assign n3     = words_reg[3] ^ words_reg[1];
    assign n1     = words_reg[1] ^ n2;
    assign n0     = words_reg[0] ^ n3;
    assign times5 = words_reg[1] + {words_reg[1][W-3:0], 2'b00};

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        sel_b_next = sel_b_reg;
        ctr_next   = ctr_reg;
        mul_a_next = mul_a_reg;
        acc_next   = acc_reg;
        word_we    = 1'b0;
        word_wd    = fin ^ (fin >> 31);
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (seed_go)
                begin
                    ctr_next   = q_cmd.seed;
                    idx_next   = '0;
                    sel_b_next = 1'b0;
                    phase_next = PH_ADD;
                end
            end
            PH_ADD:
            begin
                ctr_next   = ctr_inc;
                mul_a_next = ctr_inc ^ (ctr_inc >> 30);
                phase_next = PH_M0;
            end
            PH_M0:
            begin
                acc_next   = mul_p;
                phase_next = PH_M1;
            end
            PH_M1:
            begin
                acc_next   = acc_reg + {mul_p[H-1:0], {H{1'b0}}};
                phase_next = PH_M2;
            end
            PH_M2:
            begin
                if (!sel_b_reg)
                begin
                    mul_a_next = fin ^ (fin >> 27);
                    sel_b_next = 1'b1;
                    phase_next = PH_M0;
                end
                else
                begin
                    word_we    = 1'b1;
                    sel_b_next = 1'b0;
                    if (idx_reg == xs_pkg::IDX_W'(xs_pkg::WORD_COUNT - 1))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        phase_next = PH_ADD;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        mid_next       = mid_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (draw_go)
        begin
            mid_valid_next = 1'b1;
            mid_next       = {times5[W-8:0], times5[W-1:W-7]};
        end
        else if (mid_advance)
        begin
            mid_valid_next = 1'b0;
        end
        if (mid_advance)
        begin
            out_valid_next = 1'b1;
            out_next       = mid_reg + {mid_reg[W-4:0], 3'b000};
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // reset starts the expansion of seed zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ADD;
            idx_reg       <= '0;
            sel_b_reg     <= 1'b0;
            ctr_reg       <= '0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            sel_b_reg     <= sel_b_next;
            ctr_reg       <= ctr_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg <= mul_a_next;
        acc_reg   <= acc_next;
        mid_reg   <= mid_next;
        out_reg   <= out_next;
        if (draw_go)
        begin
            words_reg[0] <= n0;
            words_reg[1] <= n1;
            words_reg[2] <= n2 ^ {words_reg[1][W-18:0], 17'd0};
            words_reg[3] <= {n3[W-46:0], n3[W-1:W-45]};
        end
        else if (word_we)
        begin
            words_reg[idx_reg] <= word_wd;
        end
    end

endmodule
`default_nettype wire
